// ===== sv/dns_record_name_decoder_defines.svh =====
// assertion macros shared by the name decoder
// depends on nothing
`ifndef DNS_RECORD_NAME_DECODER_DEFINES_SVH
`define DNS_RECORD_NAME_DECODER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define DND_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the following cycle
`define DND_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/dnd_pkg.sv =====
// shared types and constants of the dns name decoder
// depends on nothing
package dnd_pkg;
    localparam logic [8:0] CAP_MAX     = 9'd280;
    localparam logic [8:0] CAP_MIN     = 9'd2;
    localparam logic [7:0] DOT_CHAR    = 8'h2e;
    localparam logic [1:0] PTR_TAG     = 2'b11;
    localparam int unsigned RESULT_LIMIT = 36;

    localparam logic       OP_WRITE  = 1'b0;
    localparam logic       OP_DECODE = 1'b1;
    localparam logic       KIND_CHUNK   = 1'b0;
    localparam logic       KIND_TRAILER = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_TRUNC  = 2'd1;
    localparam logic [1:0] ST_HOPS   = 2'd2;
    localparam logic [1:0] ST_BEYOND = 2'd3;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LEN   = 9'b000000010,
        S_PTR   = 9'b000000100,
        S_CHAR  = 9'b000001000,
        S_FLUSH = 9'b000010000,
        S_TRL   = 9'b000100000,
        S_TWAIT = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;
endpackage

// ===== sv/dnd_ram.sv =====
// generic single port ram with registered read
// depends on nothing
module dnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== sv/dns_record_name_decoder.sv =====
// dns record name decoder: top level with controller and message ram
// depends on dnd_pkg, dnd_ram and dns_record_name_decoder_defines.svh
//
// usage:
//   s_ channel carries one transaction per operation. operation 0 writes
//   data_byte into the message ram at offset (no result).
//   operation 1 decodes the record at offset: the name is walked through
//   the ram one byte per cycle while the output does not stall (label length
//   and pointer bytes wait for the registered ram read), compression pointers are
//   followed up to MAX_POINTER_HOPS times.
//   m_ channel returns name chunks of up to CHUNK_CHARS characters, then one
//   trailer transaction (last=1) with type, class, ttl, rdata length,
//   next offset and status.
//   the trailer reads 4 fixed bytes, or 10 when record_kind is 1. one decode
//   at a time, the ram port sets the pace.
//   reset clears the controller and sets name_capacity to 280; the ram
//   contents are undefined until written.
//   when m_ready is low, the held result stays on m_ and the walk pauses
//   once its next result is ready, until the held one is taken.
//   cfg channel writes name_capacity; write it only while idle.
module dns_record_name_decoder #(
    parameter int MESSAGE_BYTES    = 512,
    parameter int MAX_POINTER_HOPS = 16,
    parameter int CHUNK_CHARS      = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [8:0]  s_offset,
    input  logic [7:0]  s_data_byte,
    input  logic        s_record_kind,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_item_kind,
    output logic [63:0] m_name_chunk,
    output logic [3:0]  m_chunk_count,
    output logic [15:0] m_rec_type,
    output logic [15:0] m_rec_class,
    output logic [31:0] m_time_to_live,
    output logic [15:0] m_rdata_length,
    output logic [9:0]  m_next_offset,
    output logic [1:0]  m_status,
    output logic        m_last
);
    `include "dns_record_name_decoder_defines.svh"

    localparam int AW  = $clog2(MESSAGE_BYTES);
    // walk position, room past the end and for any 14-bit pointer target
    localparam int PW  = (AW + 2 > 15) ? AW + 2 : 15;
    localparam int HW  = $clog2(MAX_POINTER_HOPS + 1);
    localparam int CW  = $clog2(CHUNK_CHARS + 1);
    localparam int CIW = (CHUNK_CHARS > 1) ? $clog2(CHUNK_CHARS) : 1;
    localparam logic [PW-1:0] MSG_END = PW'(MESSAGE_BYTES);

    // configuration register
    logic [8:0] cap_reg;

    // controller state
    dnd_pkg::state_t state_reg, state_next;
    logic [PW-1:0]  pos_reg, pos_next;          // next byte to read
    logic [PW-1:0]  endp_reg, endp_next;
    logic           jumped_reg, jumped_next;
    logic           dot_reg, dot_next;
    logic [7:0]     left_reg, left_next;        // characters left in label
    logic [7:0]     ptr_hi_reg, ptr_hi_next;
    logic [HW-1:0]  hops_reg, hops_next;
    logic [8:0]     n_reg, n_next;              // characters kept so far
    logic [8:0]     limit_reg, limit_next;      // effective capacity
    logic           rr_reg, rr_next;
    logic           beyond_reg, beyond_next;
    logic           hop_hit_reg, hop_hit_next;
    logic           trunc_reg, trunc_next;
    logic           rd_pend_reg, rd_pend_next;  // ram read issued last cycle
    logic           pend_dot_reg, pend_dot_next;
    logic [3:0]     tidx_reg, tidx_next;        // trailer byte index
    logic [79:0]    tbuf_reg, tbuf_next;        // trailer bytes, shifted in
    logic [63:0]    chunk_reg, chunk_next;
    logic [CW-1:0]  ccnt_reg, ccnt_next;

    // output register
    logic        ov_reg, ov_next;
    logic        okind_reg, okind_next;
    logic [63:0] ochunk_reg, ochunk_next;
    logic [3:0]  ocnt_reg, ocnt_next;
    logic [15:0] otype_reg, otype_next, oclass_reg, oclass_next;
    logic [31:0] ottl_reg, ottl_next;
    logic [15:0] orlen_reg, orlen_next;
    logic [9:0]  onext_reg, onext_next;
    logic [1:0]  ost_reg, ost_next;

    // ram port
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;

    dnd_ram #(.WIDTH(8), .DEPTH(MESSAGE_BYTES)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign cfg_ready = (state_reg == dnd_pkg::S_IDLE) && !ov_reg;
    assign s_ready   = (state_reg == dnd_pkg::S_IDLE) && !ov_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= dnd_pkg::CAP_MAX;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    // effective capacity for a new decode
    logic [8:0] cap_eff;
    always_comb begin
        logic [8:0] c;
        c = cap_reg;
        if (c < dnd_pkg::CAP_MIN) c = dnd_pkg::CAP_MIN;
        if (c > dnd_pkg::CAP_MAX) c = dnd_pkg::CAP_MAX;
        c = c - 9'd1;
        if (32'(c) > (dnd_pkg::RESULT_LIMIT - 1) * CHUNK_CHARS) begin
            c = 9'((dnd_pkg::RESULT_LIMIT - 1) * CHUNK_CHARS);
        end
        cap_eff = c;
    end

    logic out_free;
    assign out_free = !ov_reg || m_ready;

    // trailer fields taken from the shifted bytes
    logic [PW+16:0] next_sum;
    logic [9:0]     next_sat;
    always_comb begin
        if (rr_reg) begin
            next_sum = (PW+17)'(endp_reg) + (PW+17)'(10) + (PW+17)'(tbuf_reg[15:0]);
        end else begin
            next_sum = (PW+17)'(endp_reg) + (PW+17)'(4);
        end
        if (next_sum > (PW+17)'(MESSAGE_BYTES)) begin
            next_sat = 10'(MESSAGE_BYTES);
        end else begin
            next_sat = 10'(next_sum);
        end
    end

    always_comb begin
        logic [CIW-1:0] ci;
        logic           keep;
        logic [7:0]     ch;
        logic [3:0]     tlen;
        state_next    = state_reg;
        pos_next      = pos_reg;
        endp_next     = endp_reg;
        jumped_next   = jumped_reg;
        dot_next      = dot_reg;
        left_next     = left_reg;
        ptr_hi_next   = ptr_hi_reg;
        hops_next     = hops_reg;
        n_next        = n_reg;
        limit_next    = limit_reg;
        rr_next       = rr_reg;
        beyond_next   = beyond_reg;
        hop_hit_next  = hop_hit_reg;
        trunc_next    = trunc_reg;
        rd_pend_next  = 1'b0;
        pend_dot_next = pend_dot_reg;
        tidx_next     = tidx_reg;
        tbuf_next     = tbuf_reg;
        chunk_next    = chunk_reg;
        ccnt_next     = ccnt_reg;
        ov_next       = ov_reg && !m_ready;
        okind_next    = okind_reg;
        ochunk_next   = ochunk_reg;
        ocnt_next     = ocnt_reg;
        otype_next    = otype_reg;
        oclass_next   = oclass_reg;
        ottl_next     = ottl_reg;
        orlen_next    = orlen_reg;
        onext_next    = onext_reg;
        ost_next      = ost_reg;
        ram_we        = 1'b0;
        ram_addr      = pos_reg[AW-1:0];
        ram_wdata     = s_data_byte;
        ci            = CIW'(ccnt_reg);
        keep          = 1'b0;
        ch            = ram_rdata;
        tlen          = rr_reg ? 4'd10 : 4'd4;

        unique case (state_reg)
            dnd_pkg::S_IDLE: begin
                ram_addr = s_offset[AW-1:0];
                if (s_valid && s_ready) begin
                    if (s_operation == dnd_pkg::OP_WRITE) begin
                        ram_we = (PW'(s_offset) < MSG_END);
                    end else begin
                        pos_next     = PW'(s_offset);
                        jumped_next  = 1'b0;
                        dot_next     = 1'b0;
                        hops_next    = '0;
                        n_next       = '0;
                        limit_next   = cap_eff;
                        rr_next      = s_record_kind;
                        beyond_next  = (PW'(s_offset) >= MSG_END);
                        hop_hit_next = 1'b0;
                        trunc_next   = 1'b0;
                        chunk_next   = '0;
                        ccnt_next    = '0;
                        pend_dot_next = 1'b0;
                        if (PW'(s_offset) >= MSG_END) begin
                            endp_next  = MSG_END;
                            state_next = dnd_pkg::S_FLUSH;
                        end else begin
                            rd_pend_next = 1'b1;
                            state_next   = dnd_pkg::S_LEN;
                        end
                    end
                end
            end

            // label length or pointer byte arrives
            dnd_pkg::S_LEN: begin
                if (!rd_pend_reg) begin
                    // issue read at pos
                    if (pos_reg >= MSG_END) begin
                        beyond_next = 1'b1;
                        if (!jumped_reg) endp_next = MSG_END;
                        state_next = dnd_pkg::S_FLUSH;
                    end else begin
                        rd_pend_next = 1'b1;
                    end
                end else if (ram_rdata[7:6] == dnd_pkg::PTR_TAG) begin
                    ptr_hi_next = ram_rdata;
                    if (!jumped_reg) begin
                        jumped_next = 1'b1;
                        endp_next   = (pos_reg + PW'(2) > MSG_END) ? MSG_END
                                                                   : pos_reg + PW'(2);
                    end
                    if (pos_reg + PW'(1) >= MSG_END) begin
                        beyond_next = 1'b1;
                        state_next  = dnd_pkg::S_FLUSH;
                    end else begin
                        ram_addr     = AW'(pos_reg + PW'(1));
                        rd_pend_next = 1'b1;
                        state_next   = dnd_pkg::S_PTR;
                    end
                end else begin
                    pos_next = pos_reg + PW'(1);
                    if (ram_rdata == 8'd0) begin
                        if (!jumped_reg) endp_next = pos_reg + PW'(1);
                        state_next = dnd_pkg::S_FLUSH;
                    end else begin
                        left_next     = ram_rdata;
                        pend_dot_next = dot_reg;
                        dot_next      = 1'b1;
                        state_next    = dnd_pkg::S_CHAR;
                    end
                end
            end

            dnd_pkg::S_PTR: begin
                if (32'(hops_reg) >= MAX_POINTER_HOPS) begin
                    hop_hit_next = 1'b1;
                    state_next   = dnd_pkg::S_FLUSH;
                end else begin
                    hops_next  = hops_reg + HW'(1);
                    pos_next   = PW'({ptr_hi_reg[5:0], ram_rdata});
                    state_next = dnd_pkg::S_LEN;
                end
            end

            // one character (or pending dot) per cycle into the chunk, unless a full chunk waits for the output
            dnd_pkg::S_CHAR: begin
                if (ccnt_reg == CW'(CHUNK_CHARS)) begin
                    // chunk full: hand it over
                    if (out_free) begin
                        ov_next     = 1'b1;
                        okind_next  = dnd_pkg::KIND_CHUNK;
                        ochunk_next = chunk_reg;
                        ocnt_next   = 4'(ccnt_reg);
                        otype_next  = '0;
                        oclass_next = '0;
                        ottl_next   = '0;
                        orlen_next  = '0;
                        onext_next  = '0;
                        ost_next    = dnd_pkg::ST_OK;
                        chunk_next  = '0;
                        ccnt_next   = '0;
                    end
                end else if (pend_dot_reg) begin
                    pend_dot_next = 1'b0;
                    if (n_reg < limit_reg) begin
                        chunk_next[8*ci +: 8] = dnd_pkg::DOT_CHAR;
                        ccnt_next = ccnt_reg + CW'(1);
                        n_next    = n_reg + 9'd1;
                    end else begin
                        trunc_next = 1'b1;
                    end
                end else if (left_reg == 8'd0) begin
                    state_next = dnd_pkg::S_LEN;
                end else if (!rd_pend_reg) begin
                    if (pos_reg >= MSG_END) begin
                        beyond_next = 1'b1;
                        if (!jumped_reg) endp_next = MSG_END;
                        state_next = dnd_pkg::S_FLUSH;
                    end else begin
                        rd_pend_next = 1'b1;
                    end
                end else begin
                    keep      = (n_reg < limit_reg);
                    pos_next  = pos_reg + PW'(1);
                    left_next = left_reg - 8'd1;
                    if (keep) begin
                        chunk_next[8*ci +: 8] = ch;
                        ccnt_next = ccnt_reg + CW'(1);
                        n_next    = n_reg + 9'd1;
                    end else begin
                        trunc_next = 1'b1;
                    end
                    // read next character back to back
                    if (left_reg != 8'd1 && pos_reg + PW'(1) < MSG_END
                        && (!keep || ccnt_reg + CW'(1) != CW'(CHUNK_CHARS))) begin
                        ram_addr     = AW'(pos_reg + PW'(1));
                        rd_pend_next = 1'b1;
                    end
                end
            end

            // last partial chunk, then trailer reads
            dnd_pkg::S_FLUSH: begin
                if (ccnt_reg != '0) begin
                    if (out_free) begin
                        ov_next     = 1'b1;
                        okind_next  = dnd_pkg::KIND_CHUNK;
                        ochunk_next = chunk_reg;
                        ocnt_next   = 4'(ccnt_reg);
                        otype_next  = '0;
                        oclass_next = '0;
                        ottl_next   = '0;
                        orlen_next  = '0;
                        onext_next  = '0;
                        ost_next    = dnd_pkg::ST_OK;
                        ccnt_next   = '0;
                        chunk_next  = '0;
                    end
                end else begin
                    if (!jumped_reg && endp_reg > MSG_END) endp_next = MSG_END;
                    pos_next   = (!jumped_reg && endp_reg > MSG_END) ? MSG_END : endp_reg;
                    tidx_next  = '0;
                    tbuf_next  = '0;
                    state_next = dnd_pkg::S_TRL;
                end
            end

            dnd_pkg::S_TRL: begin
                if (tidx_reg == tlen) begin
                    state_next = dnd_pkg::S_OUT;
                end else if (pos_reg >= MSG_END) begin
                    beyond_next = 1'b1;
                    tbuf_next   = {tbuf_reg[71:0], 8'd0};
                    tidx_next   = tidx_reg + 4'd1;
                    pos_next    = pos_reg + PW'(1);
                end else begin
                    state_next = dnd_pkg::S_TWAIT;
                end
            end

            dnd_pkg::S_TWAIT: begin
                tbuf_next  = {tbuf_reg[71:0], ram_rdata};
                tidx_next  = tidx_reg + 4'd1;
                pos_next   = pos_reg + PW'(1);
                state_next = dnd_pkg::S_TRL;
            end

            dnd_pkg::S_OUT: begin
                if (out_free) begin
                    ov_next     = 1'b1;
                    okind_next  = dnd_pkg::KIND_TRAILER;
                    ochunk_next = '0;
                    ocnt_next   = '0;
                    if (rr_reg) begin
                        otype_next  = tbuf_reg[79:64];
                        oclass_next = tbuf_reg[63:48];
                        ottl_next   = tbuf_reg[47:16];
                        orlen_next  = tbuf_reg[15:0];
                    end else begin
                        otype_next  = tbuf_reg[31:16];
                        oclass_next = tbuf_reg[15:0];
                        ottl_next   = '0;
                        orlen_next  = '0;
                    end
                    onext_next = next_sat;
                    if (beyond_reg)       ost_next = dnd_pkg::ST_BEYOND;
                    else if (hop_hit_reg) ost_next = dnd_pkg::ST_HOPS;
                    else if (trunc_reg)   ost_next = dnd_pkg::ST_TRUNC;
                    else                  ost_next = dnd_pkg::ST_OK;
                    state_next = dnd_pkg::S_DONE;
                end
            end

            dnd_pkg::S_DONE: begin
                state_next = dnd_pkg::S_IDLE;
            end

            default: begin
                state_next = dnd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dnd_pkg::S_IDLE;
            ov_reg      <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ov_reg      <= ov_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        endp_reg     <= endp_next;
        jumped_reg   <= jumped_next;
        dot_reg      <= dot_next;
        left_reg     <= left_next;
        ptr_hi_reg   <= ptr_hi_next;
        hops_reg     <= hops_next;
        n_reg        <= n_next;
        limit_reg    <= limit_next;
        rr_reg       <= rr_next;
        beyond_reg   <= beyond_next;
        hop_hit_reg  <= hop_hit_next;
        trunc_reg    <= trunc_next;
        pend_dot_reg <= pend_dot_next;
        tidx_reg     <= tidx_next;
        tbuf_reg     <= tbuf_next;
        chunk_reg    <= chunk_next;
        ccnt_reg     <= ccnt_next;
        okind_reg    <= okind_next;
        ochunk_reg   <= ochunk_next;
        ocnt_reg     <= ocnt_next;
        otype_reg    <= otype_next;
        oclass_reg   <= oclass_next;
        ottl_reg     <= ottl_next;
        orlen_reg    <= orlen_next;
        onext_reg    <= onext_next;
        ost_reg      <= ost_next;
    end

    assign m_valid        = ov_reg;
    assign m_item_kind    = okind_reg;
    assign m_name_chunk   = ochunk_reg;
    assign m_chunk_count  = ocnt_reg;
    assign m_rec_type     = otype_reg;
    assign m_rec_class    = oclass_reg;
    assign m_time_to_live = ottl_reg;
    assign m_rdata_length = orlen_reg;
    assign m_next_offset  = onext_reg;
    assign m_status       = ost_reg;
    assign m_last         = okind_reg;

    // checks
    `DND_ASSERT_IMP(a_chunk_count_range, aclk, aresetn,
        m_valid && m_item_kind == dnd_pkg::KIND_CHUNK,
        m_chunk_count != 4'd0 && 32'(m_chunk_count) <= CHUNK_CHARS,
        "chunk with bad character count")
    `DND_ASSERT_IMP(a_hops_bound, aclk, aresetn, state_reg != dnd_pkg::S_IDLE,
        32'(hops_reg) <= MAX_POINTER_HOPS, "pointer hop count over limit")
    `DND_ASSERT_IMP(a_name_bound, aclk, aresetn, state_reg != dnd_pkg::S_IDLE,
        n_reg <= limit_reg, "name longer than capacity")
    `DND_ASSERT_NXT(a_trailer_ends, aclk, aresetn,
        m_valid && m_ready && m_last, state_reg == dnd_pkg::S_IDLE,
        "decode did not end after trailer")
endmodule
